>>> rtl/core/gbns_pkg.sv
// ============================================================================
// gbns_pkg
// Shared widths, constants, codes and beat types of the go-back-n sender
// window block.
// ============================================================================
package gbns_pkg;

    localparam int MSG_W     = 28;
    localparam int TIME_W    = 32;
    localparam int SEQ_W     = 8;
    localparam int IDX_W     = 20;
    localparam int LEN_W     = 9;
    localparam int WIN_W     = 8;
    localparam int TMO_W     = 16;
    localparam int RETRY_W   = 8;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    localparam int PAYLOAD_BYTES = 509;
    localparam int STAMP_DEPTH   = 256;
    localparam int STAMP_AW      = $clog2(STAMP_DEPTH);

    // exact quotient by reciprocal multiply for any MSG_W-bit length
    localparam int RECIP_SHIFT = MSG_W + $clog2(PAYLOAD_BYTES);
    localparam int RECIP_W     = MSG_W + 1;
    localparam int PROD_W      = MSG_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
        ((64'd1 << RECIP_SHIFT) + 64'(PAYLOAD_BYTES) - 64'd1) / 64'(PAYLOAD_BYTES));

    localparam logic [BYTE_W-1:0]  ACK_KIND      = 8'h03;
    localparam logic [RETRY_W-1:0] RETRY_MAX     = '1;
    localparam logic [WIN_W-1:0]   WINDOW_RESET  = 8'd4;
    localparam logic [TMO_W-1:0]   TIMEOUT_RESET = 16'd500;
    localparam logic [RETRY_W-1:0] RETRY_RESET   = 8'd5;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT   = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_SEND  = 2'd1,
        PH_DONE  = 2'd2,
        PH_ABORT = 2'd3
    } phase_t;

    typedef struct packed {
        logic                command;
        logic [MSG_W-1:0]    message_bytes;
        logic [TIME_W-1:0]   time_now;
        logic                ack_arrived;
        logic [BYTE_W-1:0]   ack_check;
        logic [BYTE_W-1:0]   ack_kind;
        logic [BYTE_W-1:0]   ack_seq;
    } item_t;

    typedef struct packed {
        logic                send_valid;
        logic [IDX_W-1:0]    send_index;
        logic [SEQ_W-1:0]    send_seq;
        logic [LEN_W-1:0]    send_length;
        logic                send_last;
        logic                ack_taken;
        logic                timed_out;
        logic                finished;
        logic                aborted;
    } result_t;

endpackage

>>> rtl/core/go_back_n_sender_window.sv
// ============================================================================
// go_back_n_sender_window
// Go-back-n sender control: packetizes a message, paces sends by a window,
// stamps send times in a memory, takes acks and goes back on timeout.
// ============================================================================
// One result beat per item beat. Items are taken one per clock unless results
// stall, and pass the update stage, then the result register. The send stamp
// memory is read (head and head plus one) in the accept cycle and the window
// update runs in the update stage, with a bypass for a stamp written in that
// same accept cycle. A start item also runs its length through a reciprocal
// multiply in the accept cycle. The result register lets a new item in while
// a finished result waits. The stamp memory needs no clearing after reset.
module go_back_n_sender_window
    import gbns_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  item_t                item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output result_t              result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    function automatic logic [BYTE_W-1:0] fold8(input logic [BYTE_W:0] s);
        logic [BYTE_W:0] f;
        logic [BYTE_W:0] g;
        f = (BYTE_W+1)'(s[BYTE_W]) + (BYTE_W+1)'(s[BYTE_W-1:0]);
        g = (BYTE_W+1)'(f[BYTE_W]) + (BYTE_W+1)'(f[BYTE_W-1:0]);
        return g[BYTE_W-1:0];
    endfunction

    // configuration
    logic [WIN_W-1:0]   window_size_reg;
    logic [TMO_W-1:0]   timeout_ticks_reg;
    logic [RETRY_W-1:0] retry_limit_reg;

    // window state
    phase_t              phase_reg, phase_next;
    logic [SEQ_W-1:0]    base_seq_reg, base_seq_next;
    logic [IDX_W-1:0]    acked_count_reg, acked_count_next;
    logic [WIN_W-1:0]    outstanding_reg, outstanding_next;
    logic [IDX_W-1:0]    total_packets_reg, total_packets_next;
    logic [LEN_W-1:0]    tail_length_reg, tail_length_next;
    logic [STAMP_AW-1:0] stamp_head_reg, stamp_head_next;
    logic [RETRY_W-1:0]  retry_count_reg, retry_count_next;

    // update stage
    logic                b_valid_reg;
    item_t               b_item_reg;
    logic [IDX_W-1:0]    b_quot_reg;
    logic [STAMP_AW-1:0] b_raddr_reg;
    logic [TIME_W-1:0]   b_rd0_reg;
    logic [TIME_W-1:0]   b_rd1_reg;
    logic                byp_valid_reg;
    logic [STAMP_AW-1:0] byp_addr_reg;
    logic [TIME_W-1:0]   byp_data_reg;

    logic                result_valid_reg;
    result_t             result_reg;

    logic [TIME_W-1:0]   stamp_mem [STAMP_DEPTH];

    logic                accept;
    logic                b_fire;
    logic [PROD_W-1:0]   quot_prod;
    logic [STAMP_AW-1:0] raddr0;
    logic [STAMP_AW-1:0] raddr1;

    logic                is_start;
    logic                is_step;
    logic [MSG_W-1:0]    quot_x_pay;
    logic [MSG_W-1:0]    rem_wide;
    logic [LEN_W-1:0]    rem;
    logic [WIN_W:0]      win_cap;
    logic [IDX_W-1:0]    next_idx;
    logic                can_send;
    logic [WIN_W-1:0]    out_sent;
    logic [STAMP_AW-1:0] stamp_waddr;
    logic [TIME_W-1:0]   oldest_stamp;
    logic [TIME_W-1:0]   age;
    logic                frame_ok;
    logic                take_ack;
    logic                tout;
    result_t             res;

    assign cfg_ready    = 1'b1;
    assign b_fire       = b_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready   = !b_valid_reg || b_fire;
    assign accept       = item_valid && item_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign quot_prod = PROD_W'(item.message_bytes) * PROD_W'(RECIP);
    assign raddr0    = stamp_head_reg;
    assign raddr1    = stamp_head_reg + STAMP_AW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg   <= WINDOW_RESET;
            timeout_ticks_reg <= TIMEOUT_RESET;
            retry_limit_reg   <= RETRY_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_WINDOW_SIZE:   window_size_reg   <= cfg_data[WIN_W-1:0];
                CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data[TMO_W-1:0];
                CFG_RETRY_LIMIT:   retry_limit_reg   <= cfg_data[RETRY_W-1:0];
                default:           ;
            endcase
        end
    end

    // stamp memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (b_fire && can_send)
        begin
            stamp_mem[stamp_waddr] <= b_item_reg.time_now;
        end
        if (accept)
        begin
            b_rd0_reg <= stamp_mem[raddr0];
            b_rd1_reg <= stamp_mem[raddr1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_item_reg   <= item;
            b_quot_reg   <= quot_prod[RECIP_SHIFT +: IDX_W];
            b_raddr_reg  <= raddr0;
            byp_addr_reg <= stamp_waddr;
            byp_data_reg <= b_item_reg.time_now;
        end
        if (b_fire)
        begin
            result_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg      <= 1'b0;
            byp_valid_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                b_valid_reg   <= 1'b1;
                byp_valid_reg <= b_fire && can_send;
            end
            else if (b_fire)
            begin
                b_valid_reg <= 1'b0;
            end
            if (b_fire)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            base_seq_reg      <= '0;
            acked_count_reg   <= '0;
            outstanding_reg   <= '0;
            total_packets_reg <= '0;
            tail_length_reg   <= '0;
            stamp_head_reg    <= '0;
            retry_count_reg   <= '0;
        end
        else if (b_fire)
        begin
            phase_reg         <= phase_next;
            base_seq_reg      <= base_seq_next;
            acked_count_reg   <= acked_count_next;
            outstanding_reg   <= outstanding_next;
            total_packets_reg <= total_packets_next;
            tail_length_reg   <= tail_length_next;
            stamp_head_reg    <= stamp_head_next;
            retry_count_reg   <= retry_count_next;
        end
    end

    // window update for the item in the update stage
    always_comb
    begin
        is_start = b_item_reg.command == CMD_START;
        is_step  = b_item_reg.command == CMD_STEP && phase_reg == PH_SEND;

        quot_x_pay = MSG_W'(b_quot_reg) * MSG_W'(PAYLOAD_BYTES);
        rem_wide   = b_item_reg.message_bytes - quot_x_pay;
        rem        = rem_wide[LEN_W-1:0];

        win_cap  = ({1'b0, window_size_reg} < (WIN_W+1)'(STAMP_DEPTH))
                 ? {1'b0, window_size_reg} : (WIN_W+1)'(STAMP_DEPTH);
        next_idx = acked_count_reg + IDX_W'(outstanding_reg);
        can_send = is_step && ({1'b0, outstanding_reg} < win_cap)
                && (next_idx < total_packets_reg);
        out_sent    = outstanding_reg + WIN_W'(can_send);
        stamp_waddr = stamp_head_reg + outstanding_reg[STAMP_AW-1:0];

        // head moved by the previous beat, or its stamp is not yet in memory
        if (byp_valid_reg && byp_addr_reg == stamp_head_reg)
            oldest_stamp = byp_data_reg;
        else if (stamp_head_reg == b_raddr_reg)
            oldest_stamp = b_rd0_reg;
        else
            oldest_stamp = b_rd1_reg;
        age = b_item_reg.time_now - oldest_stamp;

        frame_ok = fold8((BYTE_W+1)'(fold8((BYTE_W+1)'(b_item_reg.ack_check)
                       + (BYTE_W+1)'(b_item_reg.ack_kind)))
                       + (BYTE_W+1)'(b_item_reg.ack_seq)) == '1;
        take_ack = is_step && out_sent != '0 && b_item_reg.ack_arrived && frame_ok
                && b_item_reg.ack_kind == ACK_KIND && b_item_reg.ack_seq == base_seq_reg;
        // a window that was empty holds only this beat's stamp, which has age zero
        tout = is_step && !take_ack && outstanding_reg != '0
            && age > TIME_W'(timeout_ticks_reg);

        base_seq_next      = base_seq_reg;
        acked_count_next   = acked_count_reg;
        outstanding_next   = outstanding_reg;
        total_packets_next = total_packets_reg;
        tail_length_next   = tail_length_reg;
        stamp_head_next    = stamp_head_reg;
        retry_count_next   = retry_count_reg;

        if (is_start)
        begin
            total_packets_next = b_quot_reg + IDX_W'(rem != '0);
            tail_length_next   = (rem != '0) ? rem : LEN_W'(PAYLOAD_BYTES);
            acked_count_next   = '0;
            outstanding_next   = '0;
            stamp_head_next    = '0;
            retry_count_next   = '0;
        end
        else if (is_step)
        begin
            outstanding_next = out_sent;
            if (take_ack)
            begin
                stamp_head_next  = stamp_head_reg + STAMP_AW'(1);
                outstanding_next = out_sent - WIN_W'(1);
                base_seq_next    = base_seq_reg + SEQ_W'(1);
                acked_count_next = acked_count_reg + IDX_W'(1);
                retry_count_next = '0;
            end
            else if (tout)
            begin
                outstanding_next = '0;
                if (retry_count_reg != RETRY_MAX)
                    retry_count_next = retry_count_reg + RETRY_W'(1);
            end
        end
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (is_start)
        begin
            phase_next = (total_packets_next == '0) ? PH_DONE : PH_SEND;
        end
        else if (is_step)
        begin
            if (acked_count_next >= total_packets_reg)
                phase_next = PH_DONE;
            else if (retry_count_next >= retry_limit_reg)
                phase_next = PH_ABORT;
        end
    end

    // result beat
    always_comb
    begin
        res             = '0;
        res.send_valid  = can_send;
        res.ack_taken   = take_ack;
        res.timed_out   = tout;
        res.finished    = phase_next == PH_DONE;
        res.aborted     = phase_next == PH_ABORT;
        if (can_send)
        begin
            res.send_index  = next_idx;
            res.send_seq    = base_seq_reg + outstanding_reg;
            res.send_last   = next_idx == total_packets_reg - IDX_W'(1);
            res.send_length = res.send_last ? tail_length_reg : LEN_W'(PAYLOAD_BYTES);
        end
    end

    a_window_in_message: assert property (@(posedge clk) disable iff (!rst_n)
        ((IDX_W+1)'(acked_count_reg) + (IDX_W+1)'(outstanding_reg))
            <= (IDX_W+1)'(total_packets_reg))
        else $error("window runs past the end of the message");

    a_ack_moves_base: assert property (@(posedge clk) disable iff (!rst_n)
        (b_fire && take_ack) |=> (base_seq_reg == $past(base_seq_reg) + SEQ_W'(1)))
        else $error("taken ack did not advance the base");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.finished && result.aborted))
        else $error("finished and aborted both set");

endmodule
